/* src/http_json_field_extractor_defines.svh */
// ---------------------------------------------------------------------------
// HTTP JSON field extractor: assertion macros
// Concurrent assertion wrappers clocked on aclk; ASSERT_OFF removes them.
// ---------------------------------------------------------------------------
`ifndef HTTP_JSON_FIELD_EXTRACTOR_DEFINES_SVH
`define HTTP_JSON_FIELD_EXTRACTOR_DEFINES_SVH
`ifndef ASSERT_OFF
// check outside reset
`define HJFE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("hjfe: assertion failed");
// check at every edge, reset included
`define HJFE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("hjfe: assertion failed");
`else
`define HJFE_ASSERT(lbl, prop)
`define HJFE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* src/hjfe_pkg.sv */
// ---------------------------------------------------------------------------
// HTTP JSON field extractor package
// Parser phases, delimiter codes, character constants and literal tables.
// ---------------------------------------------------------------------------
package hjfe_pkg;

    localparam int KEY_MAX_DEF     = 32;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int COLOR_LEN       = 5;

    localparam logic [7:0] IGNORED_RESET = 8'd13;

    typedef enum logic [3:0] {
        PH_HEADER          = 4'd0,
        PH_HEADER_EMPTY    = 4'd1,
        PH_BODY            = 4'd2,
        PH_KEY             = 4'd3,
        PH_AFTER_KEY       = 4'd4,
        PH_AFTER_COLOR_KEY = 4'd5,
        PH_BEFORE_VALUE    = 4'd6,
        PH_BEFORE_COLOR    = 4'd7,
        PH_COLOR           = 4'd8,
        PH_DELIM           = 4'd9,
        PH_NUMERIC         = 4'd10,
        PH_LITERAL         = 4'd11,
        PH_CLOSED          = 4'd12,
        PH_FINISHED        = 4'd13,
        PH_ERROR           = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        D_NONE    = 2'd0,
        D_BRACKET = 2'd1,
        D_BRACE   = 2'd2,
        D_QUOTE   = 2'd3
    } delim_t;

    typedef enum logic [1:0] {
        LIT_NONE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2,
        LIT_TRUE  = 2'd3
    } lit_kind_t;

    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_T        = 8'h74;

    function automatic logic [7:0] color_char_at(input logic [2:0] pos);
        case (pos)
            3'd0:    return 8'h63; // c
            3'd1:    return 8'h6F; // o
            3'd2:    return 8'h6C; // l
            3'd3:    return 8'h6F; // o
            3'd4:    return 8'h72; // r
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] lit_len(input lit_kind_t kind);
        case (kind)
            LIT_FALSE: return 3'd5;
            LIT_NULL:  return 3'd4;
            LIT_TRUE:  return 3'd4;
            default:   return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] lit_char(input lit_kind_t kind, input logic [2:0] pos);
        logic [39:0] text;
        case (kind)
            LIT_FALSE: text = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66}; // false
            LIT_NULL:  text = {8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E}; // null
            LIT_TRUE:  text = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74}; // true
            default:   text = '0;
        endcase
        case (pos)
            3'd0:    return text[7:0];
            3'd1:    return text[15:8];
            3'd2:    return text[23:16];
            3'd3:    return text[31:24];
            3'd4:    return text[39:32];
            default: return 8'h00;
        endcase
    endfunction

endpackage

/* src/http_json_field_extractor.sv */
// The extractor takes one response byte per clock while s_tready is high and returns one
// result per byte: the parser phase after that byte and, inside the value of a key
// starting with "color", the value character with its flag. The whole parser step,
// including the single read of the delimiter stack top, fits between the state registers
// and the result register. The result register is backed by a skid stage, so s_tready
// falls only when a stalled result and one more item are both held.
// ---------------------------------------------------------------------------
// HTTP JSON field extractor
// Skips the HTTP header up to an empty line, walks a flat JSON object and
// streams out the characters of a color value.
// ---------------------------------------------------------------------------
`include "http_json_field_extractor_defines.svh"

module http_json_field_extractor #(
    parameter int KEY_MAX     = hjfe_pkg::KEY_MAX_DEF,
    parameter int STACK_DEPTH = hjfe_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: ignored_char
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic [0:0]  s_tuser,   // [0] req_type
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] parser_phase, [11:4] color_char, [15:12] zero
    output logic [1:0]  m_tuser    // [0] color_valid, [1] color_cleared
);
    import hjfe_pkg::*;

    localparam int KL_W    = $clog2(KEY_MAX + 1);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // configuration
    logic [7:0] ignored_char_reg;

    // parser state
    phase_t            phase_reg, phase_next;
    logic [KL_W-1:0]   key_length_reg, key_length_next;
    logic [7:0]        key_store_reg [COLOR_LEN];
    delim_t            delim_stack_reg [STACK_DEPTH];
    logic [DEPTH_W-1:0] delim_depth_reg, delim_depth_next;
    lit_kind_t         literal_kind_reg, literal_kind_next;
    logic [2:0]        literal_pos_reg, literal_pos_next;

    // step logic
    logic               accept;
    logic [7:0]         c;
    logic               key_wr;
    logic               key_is_color;
    logic [DEPTH_W-1:0] depth_base;
    logic [DEPTH_W-1:0] depth_dec;
    delim_t             top;
    phase_t             d_phase;
    logic [DEPTH_W-1:0] d_depth;
    logic               d_push;
    delim_t             d_code;
    logic               push_en;
    logic [2:0]         lit_pos_inc;
    logic               res_valid;
    logic               res_cleared;

    // output register and skid stage
    logic        out_valid_reg;
    logic [3:0]  out_phase_reg;
    logic [7:0]  out_char_reg;
    logic        out_cvalid_reg;
    logic        out_cleared_reg;
    logic        skid_valid_reg;
    logic [3:0]  skid_phase_reg;
    logic [7:0]  skid_char_reg;
    logic        skid_cvalid_reg;
    logic        skid_cleared_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign c         = s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignored_char_reg <= IGNORED_RESET;
        end else if (cfg_valid) begin
            ignored_char_reg <= cfg_data;
        end
    end

    // key compare: only the first five bytes of a key matter
    always_comb begin
        key_is_color = (key_length_reg >= KL_W'(COLOR_LEN));
        for (int i = 0; i < COLOR_LEN; i++) begin
            if (key_store_reg[i] != color_char_at(3'(i))) begin
                key_is_color = 1'b0;
            end
        end
    end

    // a value start restarts the stack from empty
    assign depth_base = (phase_reg == PH_BEFORE_VALUE) ? '0 : delim_depth_reg;
    assign depth_dec  = depth_base - DEPTH_W'(1);
    assign top        = (depth_base == '0) ? D_NONE : delim_stack_reg[depth_dec[IDX_W-1:0]];

    // one byte of a bracketed or quoted value
    always_comb begin
        d_phase = PH_DELIM;
        d_depth = depth_base;
        d_push  = 1'b0;
        d_code  = D_NONE;
        case (c)
            CH_LBRACKET: begin
                d_push = 1'b1;
                d_code = D_BRACKET;
            end
            CH_LBRACE: begin
                d_push = 1'b1;
                d_code = D_BRACE;
            end
            CH_QUOTE: begin
                if (top == D_QUOTE) begin
                    d_depth = depth_dec;
                end else begin
                    d_push = 1'b1;
                    d_code = D_QUOTE;
                end
            end
            CH_RBRACKET: begin
                if (top == D_BRACKET) begin
                    d_depth = depth_dec;
                end else begin
                    d_phase = PH_ERROR;
                end
            end
            CH_RBRACE: begin
                if (top == D_BRACE) begin
                    d_depth = depth_dec;
                end else begin
                    d_phase = PH_ERROR;
                end
            end
            default: ;
        endcase
        if (d_push) begin
            if (depth_base >= DEPTH_W'(STACK_DEPTH)) begin
                d_phase = PH_ERROR;
                d_push  = 1'b0;
            end else begin
                d_depth = depth_base + DEPTH_W'(1);
            end
        end
        if (d_depth == '0) begin
            d_phase = PH_CLOSED;
        end
    end

    assign lit_pos_inc = literal_pos_reg + 3'd1;

    always_comb begin
        phase_next        = phase_reg;
        key_length_next   = key_length_reg;
        delim_depth_next  = delim_depth_reg;
        literal_kind_next = literal_kind_reg;
        literal_pos_next  = literal_pos_reg;
        key_wr            = 1'b0;
        push_en           = 1'b0;
        res_valid         = 1'b0;
        res_cleared       = 1'b0;
        if (s_tuser[0]) begin
            phase_next = PH_HEADER;
        end else begin
            case (phase_reg)
                PH_HEADER, PH_HEADER_EMPTY: begin
                    if (c == ignored_char_reg) begin
                        phase_next = phase_reg;
                    end else if (c == CH_LF) begin
                        phase_next = (phase_reg == PH_HEADER_EMPTY) ? PH_BODY : PH_HEADER_EMPTY;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_BODY: begin
                    if (c == CH_QUOTE) begin
                        phase_next      = PH_KEY;
                        key_length_next = '0;
                    end
                end
                PH_KEY: begin
                    if (c == CH_QUOTE) begin
                        phase_next = key_is_color ? PH_AFTER_COLOR_KEY : PH_AFTER_KEY;
                    end else if (key_length_reg < KL_W'(KEY_MAX)) begin
                        key_wr          = (key_length_reg < KL_W'(COLOR_LEN));
                        key_length_next = key_length_reg + KL_W'(1);
                    end
                end
                PH_AFTER_KEY: begin
                    phase_next = (c == CH_COLON) ? PH_BEFORE_VALUE : PH_ERROR;
                end
                PH_AFTER_COLOR_KEY: begin
                    phase_next = (c == CH_COLON) ? PH_BEFORE_COLOR : PH_ERROR;
                end
                PH_BEFORE_COLOR: begin
                    if (c == CH_QUOTE) begin
                        phase_next  = PH_COLOR;
                        res_cleared = 1'b1;
                    end else begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_COLOR: begin
                    if (c == CH_QUOTE) begin
                        phase_next = PH_CLOSED;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
                PH_BEFORE_VALUE: begin
                    if (c inside {CH_LBRACE, CH_LBRACKET, CH_RBRACE, CH_RBRACKET, CH_QUOTE}) begin
                        phase_next       = d_phase;
                        delim_depth_next = d_depth;
                        push_en          = d_push;
                    end else if (c inside {[CH_0:CH_9]}) begin
                        phase_next = PH_NUMERIC;
                    end else if (c inside {CH_F, CH_N, CH_T}) begin
                        literal_kind_next = (c == CH_F) ? LIT_FALSE :
                                            (c == CH_N) ? LIT_NULL : LIT_TRUE;
                        literal_pos_next  = 3'd1;
                        phase_next        = PH_LITERAL;
                    end else begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_LITERAL: begin
                    if (literal_pos_reg < lit_len(literal_kind_reg) &&
                        lit_char(literal_kind_reg, literal_pos_reg) == c) begin
                        literal_pos_next = lit_pos_inc;
                        if (lit_pos_inc >= lit_len(literal_kind_reg)) begin
                            phase_next = PH_CLOSED;
                        end
                    end else begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_DELIM: begin
                    phase_next       = d_phase;
                    delim_depth_next = d_depth;
                    push_en          = d_push;
                end
                PH_NUMERIC: begin
                    if (c == CH_COMMA) begin
                        phase_next = PH_BODY;
                    end
                end
                PH_CLOSED: begin
                    if (c == CH_COMMA) begin
                        phase_next = PH_BODY;
                    end else if (c == CH_RBRACE) begin
                        phase_next = PH_FINISHED;
                    end else begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_FINISHED: begin
                    phase_next = PH_ERROR;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            key_length_reg   <= '0;
            delim_depth_reg  <= '0;
            literal_kind_reg <= LIT_NONE;
            literal_pos_reg  <= '0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            key_length_reg   <= key_length_next;
            delim_depth_reg  <= delim_depth_next;
            literal_kind_reg <= literal_kind_next;
            literal_pos_reg  <= literal_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && key_wr) begin
            key_store_reg[key_length_reg[2:0]] <= c;
        end
        if (accept && push_en) begin
            delim_stack_reg[depth_base[IDX_W-1:0]] <= d_code;
        end
    end

    // result register with skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_phase_reg   <= skid_phase_reg;
                out_char_reg    <= skid_char_reg;
                out_cvalid_reg  <= skid_cvalid_reg;
                out_cleared_reg <= skid_cleared_reg;
            end else begin
                out_phase_reg   <= phase_next;
                out_char_reg    <= res_valid ? c : 8'h00;
                out_cvalid_reg  <= res_valid;
                out_cleared_reg <= res_cleared;
            end
        end else if (accept) begin
            skid_phase_reg   <= phase_next;
            skid_char_reg    <= res_valid ? c : 8'h00;
            skid_cvalid_reg  <= res_valid;
            skid_cleared_reg <= res_cleared;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_char_reg, out_phase_reg};
    assign m_tuser  = {out_cleared_reg, out_cvalid_reg};

    `HJFE_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg)
    `HJFE_ASSERT(a_stall_fills_skid, (accept && out_valid_reg && !m_tready) |=> skid_valid_reg)
    `HJFE_ASSERT(a_depth_bound, delim_depth_reg <= DEPTH_W'(STACK_DEPTH))
    `HJFE_ASSERT(a_restart_header, (accept && s_tuser[0]) |=> (phase_reg == PH_HEADER))
    `HJFE_ASSERT(a_color_in_value, (out_valid_reg && (out_cvalid_reg || out_cleared_reg)) |-> (out_phase_reg == PH_COLOR && !(out_cvalid_reg && out_cleared_reg)))

endmodule
